>>> hw/rtl/lsbwm_pkg.sv
// shared constants and types of the lsb watermark embed and extract block
package lsbwm_pkg;

  localparam int unsigned MARK_BITS_DEF = 65536;
  localparam int unsigned MAX_WIDTH_DEF = 4096;

  localparam int unsigned PIX_W      = 32;
  localparam int unsigned IMG_W_W    = 13;
  localparam int unsigned MARK_DIM_W = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [PIX_W-1:0] KEEP_MASK = 32'hFFFE_FEFE;
  localparam logic [PIX_W-1:0] LSB_MASK  = 32'h0001_0101;
  localparam logic [7:0]       TOP_BIT   = 8'h80;

  localparam logic [IMG_W_W-1:0]    IMG_W_RST  = 13'd640;
  localparam logic [MARK_DIM_W-1:0] MARK_W_RST = 9'd256;
  localparam logic [MARK_DIM_W-1:0] MARK_H_RST = 9'd256;
  localparam logic [MARK_DIM_W-1:0] MARK_DIM_MAX = 9'd256;

  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_PIXEL    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE,
    CFG_IMAGE_WIDTH,
    CFG_MARK_WIDTH,
    CFG_MARK_HEIGHT
  } cfg_reg_e;

endpackage

>>> hw/rtl/lsbwm_ram.sv
// generic single-write, single-read ram with registered read data
module lsbwm_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/lsb_watermark_embed_extract.sv
// top level of the lsb watermark embed and extract block
//
// Takes one word per clock while in_ready is high: either a watermark bit to load
// (command 0) or a carrier pixel 0xAARRGGBB (command 1). A load writes the next entry of the
// one-bit mark store and gives no result. In embed mode every pixel gives one result, the
// pixel with the low bit of blue, green and red replaced by the tiled watermark bit. In
// extract mode the three-low-bits-set test of each pixel is packed msb first into a byte,
// which leaves after eight pixels or at the end of a row (zero-filled), in bits 7..0.
// Sustained rate is one word per cycle in both directions while out_ready stays high; a
// pixel's result goes through the pixel stage, covering the registered mark store ram read,
// into the output register. A pixel stage and an output register sit between the sides, so
// input keeps flowing while one result waits to be taken. The mark store has no reset and
// no clearing pass; entries must be loaded before the image that uses them. Configuration
// must be written by the user only while idle; the block itself does not enforce it.
module lsb_watermark_embed_extract #(
  parameter int unsigned MarkBits = lsbwm_pkg::MARK_BITS_DEF,
  parameter int unsigned MaxWidth = lsbwm_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input words
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             command_i,
  input  logic [lsbwm_pkg::PIX_W-1:0]      pixel_in_i,
  input  logic                             mark_bit_i,
  input  logic                             frame_start_i,
  // result words
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lsbwm_pkg::PIX_W-1:0]      data_out_o,
  output logic                             row_end_o,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [lsbwm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lsbwm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lsbwm_pkg::*;

  // mark address width, a wider scratch width for modular sums, column width
  localparam int unsigned AW  = $clog2(MarkBits);
  localparam int unsigned SW  = ((AW > MARK_DIM_W) ? AW : MARK_DIM_W) + 1;
  localparam int unsigned CW  = $clog2(MaxWidth);
  localparam int unsigned IWW = $clog2(MaxWidth + 1);
  // conditional subtracts needed to bring a mark width below the store depth
  localparam int unsigned MW_STEPS = 256 / MarkBits + 1;

  // configuration registers
  logic                  mode_q;
  logic [IMG_W_W-1:0]    img_w_q;
  logic [MARK_DIM_W-1:0] mark_w_q;
  logic [MARK_DIM_W-1:0] mark_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_EMBED;
      img_w_q  <= IMG_W_RST;
      mark_w_q <= MARK_W_RST;
      mark_h_q <= MARK_H_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_MODE:        mode_q   <= cfg_data_i[0];
        CFG_IMAGE_WIDTH: img_w_q  <= cfg_data_i[IMG_W_W-1:0];
        CFG_MARK_WIDTH:  mark_w_q <= cfg_data_i[MARK_DIM_W-1:0];
        CFG_MARK_HEIGHT: mark_h_q <= cfg_data_i[MARK_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped sizes: zero acts as one, oversize saturates
  logic [IWW-1:0]        iw;
  logic [MARK_DIM_W-1:0] mw;
  logic [MARK_DIM_W-1:0] mh;
  logic [SW-1:0]         mw_mod;

  always_comb begin
    if (img_w_q == '0) begin
      iw = IWW'(1);
    end else if (32'(img_w_q) > 32'(MaxWidth)) begin
      iw = IWW'(MaxWidth);
    end else begin
      iw = IWW'(img_w_q);
    end
    if (mark_w_q == '0) begin
      mw = MARK_DIM_W'(1);
    end else if (mark_w_q > MARK_DIM_MAX) begin
      mw = MARK_DIM_MAX;
    end else begin
      mw = mark_w_q;
    end
    if (mark_h_q == '0) begin
      mh = MARK_DIM_W'(1);
    end else if (mark_h_q > MARK_DIM_MAX) begin
      mh = MARK_DIM_MAX;
    end else begin
      mh = mark_h_q;
    end
    // mark width reduced modulo the store depth, a few narrow steps
    mw_mod = SW'(mw);
    for (int i = 0; i < MW_STEPS; i++) begin
      if (mw_mod >= SW'(MarkBits)) begin
        mw_mod = mw_mod - SW'(MarkBits);
      end
    end
  end

  // handshake and pipeline control
  logic s1_valid_q, s1_valid_d;
  logic o_valid_q, o_valid_d;
  logic s1_adv;
  logic in_acc;
  logic pix_acc;
  logic load_acc;

  assign s1_adv     = s1_valid_q && (!o_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign pix_acc    = in_acc && (command_i == CMD_PIXEL);
  assign load_acc   = in_acc && (command_i == CMD_LOAD);

  // raster and mark counters, addr_q tracks (row base + mark column) mod store depth
  logic [AW-1:0] load_ptr_q, load_ptr_d;
  logic [CW-1:0] col_q, col_d;
  logic [7:0]    mcol_q, mcol_d;
  logic [7:0]    mrow_q, mrow_d;
  logic [AW-1:0] base_q, base_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [7:0]    acc_q, acc_d;
  logic [2:0]    pos_q, pos_d;

  // values after a frame start has cleared them
  logic [AW-1:0] load_ptr_cur;
  logic [CW-1:0] col_cur;
  logic [7:0]    mcol_cur;
  logic [7:0]    mrow_cur;
  logic [AW-1:0] base_cur;
  logic [AW-1:0] addr_cur;
  logic [7:0]    acc_cur;
  logic [2:0]    pos_cur;

  logic          last;
  logic          hit;
  logic [7:0]    acc_new;
  logic          emit;
  logic [SW-1:0] base_sum;
  logic [SW-1:0] addr_inc;
  logic [SW-1:0] ptr_inc;

  assign load_ptr_cur = frame_start_i ? '0 : load_ptr_q;
  assign col_cur      = frame_start_i ? '0 : col_q;
  assign mcol_cur     = frame_start_i ? '0 : mcol_q;
  assign mrow_cur     = frame_start_i ? '0 : mrow_q;
  assign base_cur     = frame_start_i ? '0 : base_q;
  assign addr_cur     = frame_start_i ? '0 : addr_q;
  assign acc_cur      = frame_start_i ? '0 : acc_q;
  assign pos_cur      = frame_start_i ? '0 : pos_q;

  assign last    = (32'(col_cur) + 32'd1) >= 32'(iw);
  assign hit     = (pixel_in_i & LSB_MASK) == LSB_MASK;
  assign acc_new = acc_cur | (hit ? (TOP_BIT >> pos_cur) : 8'd0);
  assign emit    = (pos_cur == 3'd7) || last;

  always_comb begin
    load_ptr_d = load_ptr_q;
    col_d      = col_q;
    mcol_d     = mcol_q;
    mrow_d     = mrow_q;
    base_d     = base_q;
    addr_d     = addr_q;
    acc_d      = acc_q;
    pos_d      = pos_q;
    base_sum   = SW'(base_cur) + mw_mod;
    if (base_sum >= SW'(MarkBits)) begin
      base_sum = base_sum - SW'(MarkBits);
    end
    addr_inc = SW'(addr_cur) + SW'(1);
    if (addr_inc == SW'(MarkBits)) begin
      addr_inc = '0;
    end
    ptr_inc = SW'(load_ptr_cur) + SW'(1);
    if (ptr_inc == SW'(MarkBits)) begin
      ptr_inc = '0;
    end

    if (load_acc) begin
      load_ptr_d = AW'(ptr_inc);
    end

    if (pix_acc) begin
      // byte packing only moves in extract mode, a frame start clears it in both
      if (mode_q == MODE_EXTRACT) begin
        if (emit) begin
          acc_d = '0;
          pos_d = '0;
        end else begin
          acc_d = acc_new;
          pos_d = pos_cur + 3'd1;
        end
      end else begin
        acc_d = acc_cur;
        pos_d = pos_cur;
      end
      if (last) begin
        col_d  = '0;
        mcol_d = '0;
        if ((9'(mrow_cur) + 9'd1) >= mh) begin
          mrow_d = '0;
          base_d = '0;
          addr_d = '0;
        end else begin
          mrow_d = mrow_cur + 8'd1;
          base_d = AW'(base_sum);
          addr_d = AW'(base_sum);
        end
      end else begin
        col_d  = col_cur + CW'(1);
        mrow_d = mrow_cur;
        base_d = base_cur;
        if ((9'(mcol_cur) + 9'd1) >= mw) begin
          mcol_d = '0;
          addr_d = base_cur;
        end else begin
          mcol_d = mcol_cur + 8'd1;
          addr_d = AW'(addr_inc);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_ptr_q <= '0;
      col_q      <= '0;
      mcol_q     <= '0;
      mrow_q     <= '0;
      base_q     <= '0;
      addr_q     <= '0;
      acc_q      <= '0;
      pos_q      <= '0;
    end else begin
      load_ptr_q <= load_ptr_d;
      col_q      <= col_d;
      mcol_q     <= mcol_d;
      mrow_q     <= mrow_d;
      base_q     <= base_d;
      addr_q     <= addr_d;
      acc_q      <= acc_d;
      pos_q      <= pos_d;
    end
  end

  // mark store: written by loads, read by embed pixels; rdata holds while the pixel waits
  logic mark_rd;
  logic ram_re;

  assign ram_re = pix_acc && (mode_q == MODE_EMBED);

  lsbwm_ram #(
    .Width (1),
    .Depth (MarkBits)
  ) u_mark_store (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (load_ptr_cur),
    .wdata_i (mark_bit_i),
    .re_i    (ram_re),
    .raddr_i (addr_cur),
    .rdata_o (mark_rd)
  );

  // pixel stage: holds one word that has a result, waiting for the ram data
  logic             s1_embed_q;
  logic [PIX_W-1:0] s1_data_q;
  logic             s1_row_end_q;
  logic             s1_load;
  logic [PIX_W-1:0] s1_result;

  assign s1_load = pix_acc && ((mode_q == MODE_EMBED) || emit);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_embed_q   <= (mode_q == MODE_EMBED);
      s1_data_q    <= (mode_q == MODE_EMBED) ? (pixel_in_i & KEEP_MASK)
                                             : {{(PIX_W-8){1'b0}}, acc_new};
      s1_row_end_q <= last;
    end
  end

  assign s1_result = (s1_embed_q && mark_rd) ? (s1_data_q | LSB_MASK) : s1_data_q;

  // output register
  logic [PIX_W-1:0] o_data_q;
  logic             o_row_end_q;

  always_comb begin
    o_valid_d = o_valid_q;
    if (s1_adv) begin
      o_valid_d = 1'b1;
    end else if (out_ready_i) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else begin
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      o_data_q    <= s1_result;
      o_row_end_q <= s1_row_end_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign data_out_o  = o_data_q;
  assign row_end_o   = o_row_end_q;

  // checks
  a_addr_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(addr_q) < MarkBits)
    else $error("mark address outside store");

  a_base_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(base_q) < MarkBits)
    else $error("mark row base outside store");

  a_byte_full_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_acc && (mode_q == MODE_EXTRACT) && (pos_cur == 3'd7)) |=> s1_valid_q)
    else $error("eighth extract pixel gave no byte");

  a_pixel_stage_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_data_q)))
    else $error("waiting pixel stage word lost");

  a_embed_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_acc && (mode_q == MODE_EMBED)) |=> (s1_valid_q && s1_embed_q))
    else $error("embed pixel gave no result");

endmodule

>>> test/tb_lsb_watermark_embed_extract.sv
// self-checking testbench for the lsb watermark embed and extract block
`timescale 1ns / 1ps

module tb_lsb_watermark_embed_extract;
  import lsbwm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned HOLD_OFF_LEN   = 60;

  // one result word as the block hands it over
  typedef struct packed {
    logic [PIX_W-1:0] data;
    logic             row_end;
  } out_word_t;

  // predicts the result words from the accepted input words and checks them in order
  class watermark_scoreboard;
    logic                  mode;
    logic [IMG_W_W-1:0]    image_width;
    logic [MARK_DIM_W-1:0] mark_width;
    logic [MARK_DIM_W-1:0] mark_height;

    bit          mark_store   [MARK_BITS_DEF];
    bit          mark_written [MARK_BITS_DEF];
    int unsigned load_ptr;
    int unsigned column;
    int unsigned mark_col;
    int unsigned mark_row;
    int unsigned row_base;
    logic [7:0]  byte_acc;
    int unsigned bit_pos;

    out_word_t expected_out [$];
    int        errors;

    function new();
      mode        = MODE_EMBED;
      image_width = IMG_W_RST;
      mark_width  = MARK_W_RST;
      mark_height = MARK_H_RST;
      load_ptr    = 0;
      errors      = 0;
      clear_raster();
    endfunction

    function void clear_raster();
      column   = 0;
      mark_col = 0;
      mark_row = 0;
      row_base = 0;
      byte_acc = '0;
      bit_pos  = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MODE:        mode        = val[0];
        CFG_IMAGE_WIDTH: image_width = val[IMG_W_W-1:0];
        CFG_MARK_WIDTH:  mark_width  = val[MARK_DIM_W-1:0];
        CFG_MARK_HEIGHT: mark_height = val[MARK_DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // true when the next pixel without frame start reads a mark entry already loaded
    function bit mark_read_ok();
      return (mode != MODE_EMBED) || mark_written[(row_base + mark_col) % MARK_BITS_DEF];
    endfunction

    function int pending();
      return expected_out.size();
    endfunction

    function void note_word(logic cmd, logic [PIX_W-1:0] pix, logic mbit, logic start);
      int unsigned iw;
      int unsigned mw;
      int unsigned mh;
      int unsigned addr;
      logic        last;
      out_word_t   res;
      if (cmd == CMD_LOAD) begin
        if (start) load_ptr = 0;
        mark_store[load_ptr]   = mbit;
        mark_written[load_ptr] = 1'b1;
        load_ptr = (load_ptr + 1) % MARK_BITS_DEF;
        return;
      end
      iw = clamp(32'(image_width), MAX_WIDTH_DEF);
      mw = clamp(32'(mark_width), 32'(MARK_DIM_MAX));
      mh = clamp(32'(mark_height), 32'(MARK_DIM_MAX));
      if (start) clear_raster();
      last = (column + 1 >= iw);
      if (mode == MODE_EMBED) begin
        addr     = (row_base + mark_col) % MARK_BITS_DEF;
        res.data = pix & KEEP_MASK;
        if (mark_store[addr]) res.data = res.data | LSB_MASK;
        res.row_end = last;
        expected_out.push_back(res);
      end else begin
        if ((pix & LSB_MASK) == LSB_MASK) byte_acc = byte_acc | (TOP_BIT >> bit_pos);
        bit_pos++;
        if (bit_pos >= 8 || last) begin
          res.data    = {24'h0, byte_acc};
          res.row_end = last;
          expected_out.push_back(res);
          byte_acc = '0;
          bit_pos  = 0;
        end
      end
      if (last) begin
        column   = 0;
        mark_col = 0;
        mark_row++;
        if (mark_row >= mh) begin
          mark_row = 0;
          row_base = 0;
        end else begin
          row_base += mw;
        end
      end else begin
        column++;
        mark_col++;
        if (mark_col >= mw) mark_col = 0;
      end
    endfunction

    function void check_word(logic [PIX_W-1:0] data, logic row_end);
      out_word_t exp_w;
      if (expected_out.size() == 0) begin
        $display("%0t: unexpected word data %h row_end %b", $time, data, row_end);
        errors++;
        return;
      end
      exp_w = expected_out.pop_front();
      if (data !== exp_w.data) begin
        $display("%0t: data_out expected %h actual %h", $time, exp_w.data, data);
        errors++;
      end
      if (row_end !== exp_w.row_end) begin
        $display("%0t: row_end expected %b actual %b", $time, exp_w.row_end, row_end);
        errors++;
      end
    endfunction
  endclass

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  // block inputs, all known from time zero
  logic                  in_valid    = 1'b0;
  logic                  command     = CMD_LOAD;
  logic [PIX_W-1:0]      pixel_in    = '0;
  logic                  mark_bit    = 1'b0;
  logic                  frame_start = 1'b0;
  logic                  out_ready   = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  logic             in_ready;
  logic             out_valid;
  logic [PIX_W-1:0] data_out;
  logic             row_end;

  // idling controls for the sender and the receiver, and the watchdog's quiet count
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_off  = 0;
  int unsigned quiet_cycles;

  watermark_scoreboard sb;

  lsb_watermark_embed_extract u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .command_i     (command),
    .pixel_in_i    (pixel_in),
    .mark_bit_i    (mark_bit),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .data_out_o    (data_out),
    .row_end_o     (row_end),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // monitor: note accepted input words first, then check the result word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_word(command, pixel_in, mark_bit, frame_start);
      if (out_valid && out_ready) sb.check_word(data_out, row_end);
    end
  end

  // receiver: random stalls, or a long hold-off counted down here
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off  = hold_off - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog: too many cycles with no word moving on either side
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[lsb_watermark_embed_extract] ERROR");
    $finish;
  end

  // pixel with the three colour low bits all set about half the time
  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] p;
    p = $urandom();
    if ($urandom_range(1)) p = p | LSB_MASK;
    return p;
  endfunction

  // offers one word and returns at the edge that accepts it;
  // valid stays high so back-to-back words need no gap
  task automatic send_word(input logic cmd, input logic [PIX_W-1:0] pix,
                           input logic mbit, input logic start);
    logic fs;
    fs = start;
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    // never let an embed pixel read a mark entry that was not loaded yet
    if (cmd == CMD_PIXEL && !fs && !sb.mark_read_ok()) fs = 1'b1;
    in_valid    <= 1'b1;
    command     <= cmd;
    pixel_in    <= pix;
    mark_bit    <= mbit;
    frame_start <= fs;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // extract pixels can leave no result, so give the pipeline time to empty
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic write_all(input logic md, input logic [CFG_DATA_W-1:0] iw,
                           input logic [CFG_DATA_W-1:0] mw, input logic [CFG_DATA_W-1:0] mh);
    write_reg(CFG_MODE, {12'h0, md});
    write_reg(CFG_IMAGE_WIDTH, iw);
    write_reg(CFG_MARK_WIDTH, mw);
    write_reg(CFG_MARK_HEIGHT, mh);
  endtask

  // loads n random mark bits from entry 0
  task automatic load_mark(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_word(CMD_LOAD, $urandom(), 1'($urandom_range(1)), i == 0);
    end
  endtask

  // pixel run, optionally opening a frame; noisy runs mix in loads and frame restarts
  task automatic send_pixels(input int unsigned n, input bit open_frame, input bit noisy);
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (i == 0) send_word(CMD_PIXEL, rand_pixel(), 1'($urandom_range(1)), open_frame);
      else if (noisy && r < 6) send_word(CMD_LOAD, $urandom(), 1'($urandom_range(1)), r < 2);
      else if (noisy && r < 10) send_word(CMD_PIXEL, rand_pixel(), 1'($urandom_range(1)), 1'b1);
      else send_word(CMD_PIXEL, rand_pixel(), 1'($urandom_range(1)), 1'b0);
    end
  endtask

  function automatic int unsigned eff_dim(input logic [CFG_DATA_W-1:0] v);
    int unsigned d;
    d = 32'(v[MARK_DIM_W-1:0]);
    if (d == 0) return 1;
    return (d > 32'(MARK_DIM_MAX)) ? 32'(MARK_DIM_MAX) : d;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] iw;
    logic [CFG_DATA_W-1:0] mw;
    logic [CFG_DATA_W-1:0] mh;
    logic                  md;
    int unsigned           nload;
    sb = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed part ---
    // reset settings: embed, mark bits 1 0 1 0 at entries 0..3
    for (int unsigned i = 0; i < 4; i++) send_word(CMD_LOAD, $urandom(), ~i[0], i == 0);
    send_word(CMD_PIXEL, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_word(CMD_PIXEL, 32'h0000_0000, 1'b0, 1'b0);
    send_word(CMD_PIXEL, 32'h0001_0101, 1'b1, 1'b0);
    send_word(CMD_PIXEL, 32'hFFFE_FEFE, 1'b0, 1'b0);
    // load restart mid-stream: entry 0 becomes 0, next pixel reads entry 4... only if loaded
    send_word(CMD_LOAD, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_word(CMD_PIXEL, rand_pixel(), 1'b0, 1'b0);
    settle();

    // zero width and zero mark size act as one: every pixel closes a row
    write_all(MODE_EMBED, 13'd0, 13'd0, 13'd0);
    send_pixels(2, 1'b1, 1'b0);
    send_word(CMD_LOAD, 32'h0, 1'b1, 1'b1);
    send_pixels(1, 1'b0, 1'b0);
    settle();
    write_reg(CFG_MODE, {12'h0, MODE_EXTRACT});
    send_word(CMD_PIXEL, 32'h0001_0101, 1'b0, 1'b1);
    send_word(CMD_PIXEL, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(CMD_PIXEL, 32'h0000_0101, 1'b0, 1'b0);
    send_word(CMD_PIXEL, 32'h0001_0001, 1'b0, 1'b0);
    settle();

    // full byte then zero-filled byte at row end, then a partial byte left open
    write_all(MODE_EXTRACT, 13'd10, 13'd2, 13'd2);
    send_pixels(13, 1'b1, 1'b0);
    settle();
    // mode change mid-stream: the partial byte survives the stay in embed mode
    write_reg(CFG_MODE, {12'h0, MODE_EMBED});
    load_mark(4);
    send_pixels(3, 1'b0, 1'b0);
    settle();
    write_reg(CFG_MODE, {12'h0, MODE_EXTRACT});
    send_pixels(5, 1'b0, 1'b0);
    settle();

    // --- random part: two runs per idling phase ---
    for (int unsigned k = 0; k < 8; k++) begin
      case (k / 2)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 74; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 74; end
        default: begin gap_pct = 14; stall_pct = 14; end
      endcase
      md = (k == 0) ? MODE_EMBED : logic'($urandom_range(1));
      case ($urandom_range(7))
        0: iw = 13'd0;
        1: iw = 13'd1;
        default: iw = CFG_DATA_W'($urandom_range(2, 24));
      endcase
      case ($urandom_range(5))
        0: mw = 13'd0;
        1: mw = 13'h1FFF;
        default: mw = CFG_DATA_W'($urandom_range(1, 9));
      endcase
      case ($urandom_range(5))
        0: mh = 13'd0;
        1: mh = 13'h1FFF;
        default: mh = CFG_DATA_W'($urandom_range(1, 6));
      endcase
      write_all(md, iw, mw, mh);
      nload = eff_dim(mw) * eff_dim(mh);
      if (nload > 32) nload = 32;
      load_mark(nload);
      // long receiver hold-off while the sender keeps offering pixels
      if (k == 0) hold_off = HOLD_OFF_LEN;
      if (k == 1) begin
        send_pixels(24, 1'b1, 1'b1);
        // sender pauses until every pending result is out
        drain_results();
        send_pixels(24, 1'b0, 1'b1);
      end else begin
        send_pixels(48, 1'b1, 1'b1);
      end
      settle();
    end

    // end of stimulus: wait for the last results, then a few cycles more
    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[lsb_watermark_embed_extract] OK");
    end else begin
      $display("[lsb_watermark_embed_extract] ERROR");
    end
    $finish;
  end

endmodule
